/* hdl/nwsp_pkg.sv */
// Package: shared types, constants and parameters of the waypoint speed preview block.
package nwsp_pkg;

  localparam int unsigned TableDepthDef = 1024;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CurvW  = 23;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned PrevW  = 6;
  localparam int unsigned IdxOutW = 10;
  localparam int unsigned SpdIdxW = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DistW  = 65;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_PHYS_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PHYS_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RULE_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RULE_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAIN      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PREVIEW   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_DRAIN, S_PREV, S_PREV_DRAIN,
    S_DEN, S_DIV1, S_CLAMP, S_DIV2, S_OUT
  } state_t;

  typedef struct packed {
    logic [SpeedW-1:0] phys_min;
    logic [SpeedW-1:0] phys_max;
    logic [SpeedW-1:0] rule_low;
    logic [SpeedW-1:0] rule_high;
    logic [SpeedW-1:0] gain;
    logic [PrevW-1:0]  preview;
  } cfg_t;

endpackage

/* hdl/nearest_waypoint_speed_preview.sv */
// Top level: waypoint table, nearest-point search and curvature speed rule.
// A load beat is written to the store as it is accepted; beats past a full table are dropped
// unless they start a new set. With n stored waypoints and a preview count P, a query runs
// in phases: the scan reads the n waypoints, one per cycle, from the store memory (one read
// port) and then flushes the distance pipeline, the preview reads P+1 curvatures and then
// flushes likewise, then two bit-serial divisions of 40 and 33 steps set the speed. A
// degenerate speed range, or a clamped rule speed below the physical minimum, skips the
// second division. Queries on a table of fewer than two waypoints skip the scan and the
// divisions and go straight to the output state. One beat is worked at a time; a new
// beat is taken only once the result register is empty or is being read.
module nearest_waypoint_speed_preview #(
  parameter int unsigned TABLE_DEPTH = nwsp_pkg::TableDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_operation,
  input  logic in_first_of_set,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [23:0] in_point_curvature,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_near_wp,
  output logic [16:0] out_speed_frac,
  input  logic cfg_we,
  input  logic [nwsp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nwsp_pkg::CfgDataW-1:0] cfg_data
);
  import nwsp_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CNTW = AW + 1;
  localparam int unsigned D1N = 40;
  localparam int unsigned D1D = 40;
  localparam int unsigned D2N = 33;
  localparam int unsigned D2D = 16;

  cfg_t cfg_r;
  state_t state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] i_r, i_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [CNTW-1:0] cur_r, cur_nxt;
  logic [DistW-1:0] bestd_r, bestd_nxt;
  logic [CurvW-1:0] cmax_r, cmax_nxt;
  logic [PrevW:0] off_r, off_nxt;
  logic signed [CoordW-1:0] rx_r, ry_r;
  logic [D1D-1:0] den_r, den_nxt;
  logic [SpeedW-1:0] rule_r, rule_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] st_r, st_nxt;
  logic [9:0] ni_r, ni_nxt;
  logic [16:0] si_r, si_nxt;
  logic u_div1_started_r, u_div2_started_r;

  logic rvalid_r, rvalid_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic pvalid_r, pvalid_nxt;
  logic [AW-1:0] pptr_r;
  logic [2*CoordW-1:0] sqx_r, sqy_r;

  logic wr_en;
  logic [AW-1:0] rd_addr;
  logic signed [CoordW-1:0] rd_x, rd_y;
  logic [CurvW-1:0] rd_curv;
  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0] ax, ay;
  logic [2*CoordW-1:0] sqx, sqy;
  logic [DistW-1:0] sq_sum;
  logic [SpeedW+CurvW-1:0] gain_prod;
  logic d1_start, d1_done, d2_start, d2_done;
  logic [D1N-1:0] q1;
  logic [D2N-1:0] q2;
  logic [SpeedW-1:0] span;
  logic [D2N-1:0] num2;
  logic accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !(out_valid && !out_ready);
  assign wr_en = accept && (in_operation == OP_LOAD)
                 && (in_first_of_set || count_r < CNTW'(TABLE_DEPTH));

  nwsp_store #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en),
    .wr_addr(in_first_of_set ? '0 : count_r[AW-1:0]),
    .wr_x(in_point_x), .wr_y(in_point_y),
    .wr_curv(in_point_curvature[23] ? '0 : in_point_curvature[CurvW-1:0]),
    .rd_addr(rd_addr), .rd_x(rd_x), .rd_y(rd_y), .rd_curv(rd_curv)
  );

  assign dx = {rd_x[CoordW-1], rd_x} - {rx_r[CoordW-1], rx_r};
  assign dy = {rd_y[CoordW-1], rd_y} - {ry_r[CoordW-1], ry_r};
  assign ax = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
  assign ay = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
  assign sqx = ax * ax;
  assign sqy = ay * ay;
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign gain_prod = cfg_r.gain * cmax_r;

  nwsp_div #(.NW(D1N), .DW(D1D)) u_div1 (
    .clk(clk), .rst_n(rst_n), .start(d1_start),
    .num({cfg_r.rule_high, 24'd0}), .den(den_r), .done(d1_done), .quo(q1)
  );

  assign span = cfg_r.phys_max - cfg_r.phys_min;
  assign num2 = {1'b0, rule_r - cfg_r.phys_min, 16'd0};

  nwsp_div #(.NW(D2N), .DW(D2D)) u_div2 (
    .clk(clk), .rst_n(rst_n), .start(d2_start),
    .num(num2), .den(span), .done(d2_done), .quo(q2)
  );

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; i_nxt = i_r; best_nxt = best_r;
    cur_nxt = cur_r; bestd_nxt = bestd_r; cmax_nxt = cmax_r; off_nxt = off_r;
    den_nxt = den_r; rule_nxt = rule_r; ov_nxt = ov_r; st_nxt = st_r;
    ni_nxt = ni_r; si_nxt = si_r; rvalid_nxt = 1'b0; rptr_nxt = rptr_r;
    pvalid_nxt = rvalid_r && (state_r == S_SCAN || state_r == S_SCAN_DRAIN);
    rd_addr = i_r[AW-1:0]; d1_start = 1'b0; d2_start = 1'b0;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (pvalid_r && (state_r == S_SCAN || state_r == S_SCAN_DRAIN)) begin
      if (pptr_r == '0 || sq_sum < bestd_r) begin
        bestd_nxt = sq_sum; best_nxt = pptr_r;
      end
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_LOAD) begin
            if (in_first_of_set) count_nxt = CNTW'(1);
            else if (wr_en) count_nxt = count_r + 1'b1;
          end else if (count_r < CNTW'(2)) begin
            st_nxt = (count_r == '0) ? ST_EMPTY : ST_SHORT;
            ni_nxt = '0; si_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            i_nxt = '0; state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = i_r[AW-1:0];
        rvalid_nxt = 1'b1; rptr_nxt = i_r[AW-1:0];
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == count_r) state_nxt = S_SCAN_DRAIN;
      end
      S_SCAN_DRAIN: begin
        if (!rvalid_r) begin
          cur_nxt = {1'b0, best_nxt};
          off_nxt = '0; cmax_nxt = '0;
          state_nxt = S_PREV;
        end
      end
      S_PREV: begin
        rd_addr = cur_r[AW-1:0];
        rvalid_nxt = 1'b1;
        cur_nxt = (cur_r + 1'b1 == count_r) ? '0 : cur_r + 1'b1;
        off_nxt = off_r + 1'b1;
        if (off_r == {1'b0, cfg_r.preview}) state_nxt = S_PREV_DRAIN;
      end
      S_PREV_DRAIN: begin
        if (!rvalid_r) state_nxt = S_DEN;
      end
      S_DEN: begin
        den_nxt = D1D'(gain_prod) + D1D'(32'h100_0000);
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (d1_done) state_nxt = S_CLAMP;
        else if (den_r != '0 && !u_div1_started_r) d1_start = 1'b1;
      end
      S_CLAMP: begin
        if (q1 < D1N'(cfg_r.rule_low)) rule_nxt = cfg_r.rule_low;
        else if (q1 > D1N'(cfg_r.rule_high)) rule_nxt = cfg_r.rule_high;
        else rule_nxt = q1[SpeedW-1:0];
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (cfg_r.phys_max <= cfg_r.phys_min || rule_r < cfg_r.phys_min) begin
          si_nxt = '0; st_nxt = ST_READY; ni_nxt = 10'(best_r); state_nxt = S_OUT;
        end else if (d2_done) begin
          si_nxt = (q2 > D2N'(65536)) ? 17'd65536 : q2[16:0];
          st_nxt = ST_READY; ni_nxt = 10'(best_r); state_nxt = S_OUT;
        end else if (!u_div2_started_r) begin
          d2_start = 1'b1;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (rvalid_r && (state_r == S_PREV || state_r == S_PREV_DRAIN)) begin
      if (rd_curv > cmax_nxt) cmax_nxt = rd_curv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
      rvalid_r <= 1'b0;
      pvalid_r <= 1'b0;
      u_div1_started_r <= 1'b0;
      u_div2_started_r <= 1'b0;
      cfg_r <= '{phys_min: 16'd256, phys_max: 16'd2560, rule_low: 16'd256,
                 rule_high: 16'd1536, gain: 16'd512, preview: 6'd3};
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      rvalid_r <= rvalid_nxt;
      pvalid_r <= pvalid_nxt;
      u_div1_started_r <= (state_r == S_DIV1) && !d1_done && (u_div1_started_r || d1_start);
      u_div2_started_r <= (state_r == S_DIV2) && !d2_done && (u_div2_started_r || d2_start);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHYS_MIN:  cfg_r.phys_min  <= cfg_data;
          REG_PHYS_MAX:  cfg_r.phys_max  <= cfg_data;
          REG_RULE_LOW:  cfg_r.rule_low  <= cfg_data;
          REG_RULE_HIGH: cfg_r.rule_high <= cfg_data;
          REG_GAIN:      cfg_r.gain      <= cfg_data;
          REG_PREVIEW:   cfg_r.preview   <= cfg_data[PrevW-1:0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      rx_r <= in_robot_x;
      ry_r <= in_robot_y;
    end
    i_r <= i_nxt; best_r <= best_nxt; cur_r <= cur_nxt; bestd_r <= bestd_nxt;
    cmax_r <= cmax_nxt; off_r <= off_nxt; den_r <= den_nxt; rule_r <= rule_nxt;
    st_r <= st_nxt; ni_r <= ni_nxt; si_r <= si_nxt; rptr_r <= rptr_nxt;
    sqx_r <= sqx; sqy_r <= sqy; pptr_r <= rptr_r;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_near_wp = ni_r;
  assign out_speed_frac = si_r;
endmodule

/* hdl/nwsp_store.sv */
// Waypoint store: x, y and curvature memories with one registered read port.
module nwsp_store #(
  parameter int unsigned TABLE_DEPTH = nwsp_pkg::TableDepthDef,
  parameter int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [nwsp_pkg::CoordW-1:0] wr_x,
  input  logic signed [nwsp_pkg::CoordW-1:0] wr_y,
  input  logic [nwsp_pkg::CurvW-1:0]    wr_curv,
  input  logic [AW-1:0]                 rd_addr,
  output logic signed [nwsp_pkg::CoordW-1:0] rd_x,
  output logic signed [nwsp_pkg::CoordW-1:0] rd_y,
  output logic [nwsp_pkg::CurvW-1:0]    rd_curv
);
  import nwsp_pkg::*;

  logic [CoordW-1:0] mem_x [TABLE_DEPTH];
  logic [CoordW-1:0] mem_y [TABLE_DEPTH];
  logic [CurvW-1:0]  mem_c [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_c[wr_addr] <= wr_curv;
    end
    rd_x    <= mem_x[rd_addr];
    rd_y    <= mem_y[rd_addr];
    rd_curv <= mem_c[rd_addr];
  end
endmodule

/* hdl/nwsp_div.sv */
// Restoring divider: one quotient bit per cycle.
module nwsp_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den;
      cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

/* bench/nwsp_scoreboard.sv */
// Checker: mirrors the waypoint table and speed rule and compares every result beat.
`timescale 1ns / 1ps
module nwsp_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operation,
  input  logic               in_first_of_set,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [23:0] in_point_curvature,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [9:0]         out_near_wp,
  input  logic [16:0]        out_speed_frac,
  input  logic               cfg_we,
  input  logic [nwsp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nwsp_pkg::CfgDataW-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import nwsp_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned QDepth = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  nearest;
    logic [16:0] speed;
  } preview_t;

  logic signed [31:0] way_x [Depth];
  logic signed [31:0] way_y [Depth];
  logic [22:0]        way_curv [Depth];
  int unsigned        way_count;
  cfg_t               rules;
  preview_t           expected_mem [QDepth];
  int unsigned        wr_count = 0;
  int unsigned        rd_count = 0;

  function automatic preview_t speed_preview(input logic signed [31:0] rx,
                                             input logic signed [31:0] ry);
    preview_t     res;
    logic [32:0]  ax, ay;
    logic [65:0]  d2, best_d2;
    int unsigned  best, k;
    logic [22:0]  cmax;
    logic [63:0]  denom, raw, rule, idx;
    logic signed [32:0] dx, dy;
    res = '0;
    if (way_count < 2) begin
      res.status = (way_count == 0) ? ST_EMPTY : ST_SHORT;
      return res;
    end
    best = 0;
    best_d2 = '0;
    for (int unsigned i = 0; i < way_count; i++) begin
      dx = 33'(way_x[i]) - 33'(rx);
      dy = 33'(way_y[i]) - 33'(ry);
      ax = dx[32] ? -dx : dx;
      ay = dy[32] ? -dy : dy;
      d2 = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      if (i == 0 || d2 < best_d2) begin
        best = i;
        best_d2 = d2;
      end
    end
    cmax = '0;
    for (int unsigned o = 0; o <= rules.preview; o++) begin
      k = (best + o) % way_count;
      if (way_curv[k] > cmax) cmax = way_curv[k];
    end
    denom = (64'd1 << 24) + 64'(rules.gain) * 64'(cmax);
    raw = (64'(rules.rule_high) << 24) / denom;
    if (raw < 64'(rules.rule_low)) rule = 64'(rules.rule_low);
    else if (raw > 64'(rules.rule_high)) rule = 64'(rules.rule_high);
    else rule = raw;
    if (rules.phys_max <= rules.phys_min || rule < 64'(rules.phys_min)) begin
      idx = '0;
    end else begin
      idx = ((rule - 64'(rules.phys_min)) << 16) / 64'(rules.phys_max - rules.phys_min);
      if (idx > 64'd65536) idx = 64'd65536;
    end
    res.status = ST_READY;
    res.nearest = best[9:0];
    res.speed = idx[16:0];
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t: result %s mismatch, got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = int'(wr_count - rd_count);

  always @(posedge clk) begin
    preview_t want;
    if (!rst_n) begin
      way_count <= 0;
      rules <= '{phys_min: 16'd256, phys_max: 16'd2560, rule_low: 16'd256,
                 rule_high: 16'd1536, gain: 16'd512, preview: 6'd3};
      wr_count = 0;
      rd_count = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHYS_MIN:  rules.phys_min  <= cfg_data;
          REG_PHYS_MAX:  rules.phys_max  <= cfg_data;
          REG_RULE_LOW:  rules.rule_low  <= cfg_data;
          REG_RULE_HIGH: rules.rule_high <= cfg_data;
          REG_GAIN:      rules.gain      <= cfg_data;
          REG_PREVIEW:   rules.preview   <= cfg_data[PrevW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_operation == OP_LOAD) begin
          automatic int unsigned slot = in_first_of_set ? 0 : way_count;
          if (slot < Depth) begin
            way_x[slot] = in_point_x;
            way_y[slot] = in_point_y;
            way_curv[slot] = in_point_curvature[23] ? '0 : in_point_curvature[22:0];
            way_count <= slot + 1;
          end else begin
            way_count <= slot;
          end
        end else begin
          expected_mem[wr_count % QDepth] = speed_preview(in_robot_x, in_robot_y);
          wr_count++;
        end
      end
      if (out_valid && out_ready) begin
        if (wr_count == rd_count) begin
          $display("%0t: result beat with nothing outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_mem[rd_count % QDepth];
          rd_count++;
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_near_wp !== want.nearest)
            report("near_wp", out_near_wp, want.nearest);
          if (out_speed_frac !== want.speed)
            report("speed_frac", out_speed_frac, want.speed);
        end
      end
    end
  end

endmodule

/* bench/nearest_waypoint_speed_preview_tb.sv */
// Testbench top: drives waypoint loads, queries and register settings, and gives the verdict.
`timescale 1ns / 1ps
module nearest_waypoint_speed_preview_tb;
  import nwsp_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OP_LOAD;
  logic in_first_of_set = 1'b0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [23:0] in_point_curvature = '0;
  logic signed [31:0] in_robot_x = '0;
  logic signed [31:0] in_robot_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_near_wp;
  logic [16:0] out_speed_frac;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_PHYS_MIN;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  int unsigned cycles = 0;
  logic calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nearest_waypoint_speed_preview u_dut (.*);

  nwsp_scoreboard u_scoreboard (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= calm || ($urandom_range(0, 99) >= 22);
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [23:0] pick_curv();
    case ($urandom_range(0, 7))
      0: return 24'($urandom());
      1: return 24'h7F_FFFF;
      default: return 24'($urandom_range(0, 1 << 17));
    endcase
  endfunction

  task automatic send_beat(input logic op, input logic first, input logic [31:0] px,
                           input logic [31:0] py, input logic [23:0] pc,
                           input logic [31:0] rx, input logic [31:0] ry);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_first_of_set <= first;
    in_point_x <= px;
    in_point_y <= py;
    in_point_curvature <= pc;
    in_robot_x <= rx;
    in_robot_y <= ry;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic load_point(input logic first, input logic [31:0] px,
                            input logic [31:0] py, input logic [23:0] pc);
    send_beat(OP_LOAD, first, px, py, pc, $urandom(), $urandom());
  endtask

  task automatic query_at(input logic [31:0] rx, input logic [31:0] ry);
    send_beat(OP_QUERY, 1'($urandom()), $urandom(), $urandom(), 24'($urandom()), rx, ry);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_rules(input logic [15:0] pmin, input logic [15:0] pmax,
                           input logic [15:0] rlow, input logic [15:0] rhigh,
                           input logic [15:0] gain, input logic [5:0] prev);
    logic [15:0] vals [6];
    vals = '{pmin, pmax, rlow, rhigh, gain, 16'(prev)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int beats);
    int left;
    int set_len;
    left = beats;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          load_point(1'($urandom()), pick_coord(), pick_coord(), pick_curv());
        else query_at(pick_coord(), pick_coord());
        left--;
      end else begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
        if (set_len == 0) begin
          load_point(1'b1, pick_coord(), pick_coord(), pick_curv());
          left--;
        end
        for (int i = 0; i < set_len; i++)
          load_point(i == 0, pick_coord(), pick_coord(), pick_curv());
        for (int q = $urandom_range(1, 4); q > 0; q--) query_at(pick_coord(), pick_coord());
        left -= set_len + 2;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    query_at(32'h0, 32'h0);
    load_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 24'h7F_FFFF);
    query_at(32'h7FFF_FFFF, 32'h8000_0000);
    load_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 24'h80_0000);
    load_point(1'b0, 32'h0, 32'h0, 24'hFF_FFFF);
    query_at(32'h8000_0000, 32'h7FFF_FFFF);
    query_at(32'h7FFF_FFFF, 32'h8000_0000);
    query_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_point(1'b1, 32'h0001_0000, 32'h0, 24'h00_1000);
    load_point(1'b0, 32'hFFFF_0000, 32'h0, 24'h01_0000);
    load_point(1'b0, 32'h0, 32'h0, 24'h00_0000);
    query_at(32'h0, 32'h0);
    drain();

    for (int i = 0; i < 40; i++)
      load_point(i == 0, 32'(i) << 16, 32'h0, (i % 7 == 0) ? 24'h02_0000 : 24'h00_0100);
    query_at(32'h7FFF_FFFF, 32'h0);
    query_at(32'h8000_0000, 32'h0);
    drain();
    set_rules(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 6'd63);
    query_at(32'h7FFF_FFFF, 32'h0);
    query_at(32'h0320_0000, 32'h0);
    drain();

    set_rules(16'd256, 16'd2560, 16'd256, 16'd1536, 16'd512, 6'd3);
    random_phase(50);
    query_at(pick_coord(), pick_coord());
    drain();
    random_phase(30);
    drain();
    set_rules(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 6'd0);
    calm <= 1'b1;
    random_phase(60);
    drain();
    calm <= 1'b0;
    set_rules(16'd2560, 16'd256, 16'd1536, 16'd256, 16'd512, 6'd63);
    random_phase(50);
    drain();
    set_rules(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 6'd1);
    random_phase(40);
    drain();
    set_rules(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
    random_phase(40);
    drain();
    set_rules(16'd100, 16'd5000, 16'd1536, 16'd256, 16'd2000, 6'd10);
    random_phase(40);
    drain();
    for (int r = 0; r < 2; r++) begin
      set_rules(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 6'($urandom()));
      random_phase(50);
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
